// File: hw/rtl/dpq_pkg.sv
// ----------------------------------------------------------------------------
// dpq_pkg
// Shared constants, codes and types of the double-ended priority queue.
// ----------------------------------------------------------------------------
package dpq_pkg;

    // Store size; a power of two so that ring addresses wrap by truncation
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int VAL_W    = 32;

    // Action codes
    localparam logic [1:0] ACT_INSERT   = 2'd0;
    localparam logic [1:0] ACT_POP_MIN  = 2'd1;
    localparam logic [1:0] ACT_POP_MAX  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_REMOVED   = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_POP  = 4'b0010,
        S_SHFT = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

endpackage

// File: hw/rtl/dpq_ram.sv
// ----------------------------------------------------------------------------
// dpq_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dpq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/double_ended_priority_queue.sv
// ----------------------------------------------------------------------------
// double_ended_priority_queue
// Bounded multiset of signed values with removal of the smallest or largest.
// ----------------------------------------------------------------------------
// Input channel s_*: s_tuser carries the action (insert, remove smallest,
// remove largest; code 3 acts as remove largest), s_tdata the value to insert.
// Output channel m_*: one transfer per input, m_tdata the removed value (zero
// otherwise), m_tuser the status (inserted, removed, empty, full).
// The values sit in ascending order in a ring held in one RAM; a head pointer
// marks the smallest entry, head + count - 1 the largest.
// A refused insert, a removal from an empty store and an insert into an
// empty store are answered straight from the idle state; a removal reads
// one RAM entry first; any other insert moves each held value larger than
// the new one up, since the single write port moves one entry up per cycle.
// One item is worked on at a time; the next is taken at the earliest in the
// cycle after its predecessor's result reaches the output register.
// Reset (synchronous, active low) empties the store; RAM contents are not
// cleared. When m_tready is low the result waits in the output register and
// s_tready stays low until it has been taken.
// ----------------------------------------------------------------------------
module double_ended_priority_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] item_value
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] out_value
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int AW = dpq_pkg::ADDR_W;
    localparam int CW = dpq_pkg::CNT_W;
    localparam int VW = dpq_pkg::VAL_W;

    dpq_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_pos, n_pos;
    logic [VW-1:0]   r_val, n_val;
    logic            r_is_min, n_is_min;
    logic            r_mvalid, n_mvalid;
    logic [VW-1:0]   r_mdata, n_mdata;
    logic [1:0]      r_muser, n_muser;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [VW-1:0]   ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [VW-1:0]   ram_rdata;

    logic            in_xfer;
    logic            is_full;
    logic            is_empty;
    logic            larger;

    dpq_ram #(
        .DEPTH(dpq_pkg::CAPACITY),
        .WIDTH(VW),
        .AW   (AW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign s_tready = (r_state == dpq_pkg::S_IDLE) && (!r_mvalid || m_tready);
    assign in_xfer  = s_tvalid && s_tready;
    assign is_full  = (r_count == CW'(dpq_pkg::CAPACITY));
    assign is_empty = (r_count == '0);
    assign larger   = $signed(ram_rdata) > $signed(r_val);

    // Sequencer: decode the action, walk the ring, build the result
    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_pos     = r_pos;
        n_val     = r_val;
        n_is_min  = r_is_min;
        n_mvalid  = r_mvalid && !m_tready;
        n_mdata   = r_mdata;
        n_muser   = r_muser;
        ram_we    = 1'b0;
        ram_waddr = r_head + r_pos;
        ram_wdata = r_val;
        ram_raddr = r_head;
        case (r_state)
            dpq_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_val = s_tdata;
                    if (s_tuser == dpq_pkg::ACT_INSERT) begin
                        if (is_full) begin
                            n_mvalid = 1'b1;
                            n_mdata  = '0;
                            n_muser  = dpq_pkg::ST_FULL;
                        end else if (is_empty) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_head;
                            ram_wdata = s_tdata;
                            n_count   = r_count + CW'(1);
                            n_mvalid  = 1'b1;
                            n_mdata   = '0;
                            n_muser   = dpq_pkg::ST_INSERTED;
                        end else begin
                            // Start the shift from the top entry
                            n_pos     = r_count[AW-1:0];
                            ram_raddr = r_head + r_count[AW-1:0] - AW'(1);
                            n_state   = dpq_pkg::S_SHFT;
                        end
                    end else if (is_empty) begin
                        n_mvalid = 1'b1;
                        n_mdata  = '0;
                        n_muser  = dpq_pkg::ST_EMPTY;
                    end else begin
                        n_is_min  = (s_tuser == dpq_pkg::ACT_POP_MIN);
                        ram_raddr = (s_tuser == dpq_pkg::ACT_POP_MIN) ? r_head
                                  : r_head + r_count[AW-1:0] - AW'(1);
                        n_state   = dpq_pkg::S_POP;
                    end
                end
            end
            dpq_pkg::S_POP: begin
                // Drop the end entry and return it
                if (r_is_min) begin
                    n_head = r_head + AW'(1);
                end
                n_count  = r_count - CW'(1);
                n_mvalid = 1'b1;
                n_mdata  = ram_rdata;
                n_muser  = dpq_pkg::ST_REMOVED;
                n_state  = dpq_pkg::S_IDLE;
            end
            dpq_pkg::S_SHFT: begin
                ram_we = 1'b1;
                if (larger) begin
                    // Move the larger entry up one place, read the next below
                    ram_wdata = ram_rdata;
                    n_pos     = r_pos - AW'(1);
                    ram_raddr = r_head + r_pos - AW'(2);
                    if (r_pos == AW'(1)) begin
                        n_state = dpq_pkg::S_FIN;
                    end
                end else begin
                    n_count  = r_count + CW'(1);
                    n_mvalid = 1'b1;
                    n_mdata  = '0;
                    n_muser  = dpq_pkg::ST_INSERTED;
                    n_state  = dpq_pkg::S_IDLE;
                end
            end
            dpq_pkg::S_FIN: begin
                // New value is the smallest: place it at the head
                ram_we   = 1'b1;
                n_count  = r_count + CW'(1);
                n_mvalid = 1'b1;
                n_mdata  = '0;
                n_muser  = dpq_pkg::ST_INSERTED;
                n_state  = dpq_pkg::S_IDLE;
            end
            default: begin
                n_state = dpq_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dpq_pkg::S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_mvalid <= n_mvalid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_is_min <= n_is_min;
        r_mdata  <= n_mdata;
        r_muser  <= n_muser;
    end

    assign m_tvalid = r_mvalid;
    assign m_tdata  = r_mdata;
    assign m_tuser  = r_muser;

endmodule
